// ----- rtl/tbb_pkg.sv -----
// tbb_pkg: shared types and constants of the typed bandwidth budget block
// no dependencies; imported by every rtl file of the block

package tbb_pkg;

  localparam int unsigned ADDR_W    = 5;
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned RATE_W    = 24;
  localparam int unsigned SHARE_W   = 9;
  localparam int unsigned TICK_W    = 24;
  localparam int unsigned BUDGET_W  = 24;
  localparam int unsigned SIZE_W    = 16;
  localparam int unsigned SETTLE_W  = 2;

  localparam logic [SHARE_W-1:0]  SHARE_ONE     = SHARE_W'(256);
  localparam logic [RATE_W-1:0]   RATE_RESET    = RATE_W'(65536);
  localparam logic [TICK_W-1:0]   RENEW_RESET   = TICK_W'(500);
  localparam logic [SETTLE_W-1:0] SETTLE_CYCLES = SETTLE_W'(2);

  typedef enum logic [1:0] {
    CMD_CHECK = 2'd0,
    CMD_USE   = 2'd1,
    CMD_CUT   = 2'd2,
    CMD_TICK  = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    REG_TOTAL_RATE = 3'd0,
    REG_SHARE_POS  = 3'd1,
    REG_SHARE_DIRTY = 3'd2,
    REG_SHARE_OTHER = 3'd3,
    REG_RENEW      = 3'd4
  } reg_idx_e;

  typedef struct packed {
    logic                 busy;
    logic [TICK_W-1:0]    renew_ticks;
  } cfg_ctrl_t;

  function automatic logic [SHARE_W-1:0] share_sat(input logic [SHARE_W-1:0] s);
    share_sat = (s > SHARE_ONE) ? SHARE_ONE : s;
  endfunction

endpackage

// ----- rtl/tbb_if.sv -----
// tbb_if: valid/ready channel interfaces for commands and results
// depends on tbb_pkg

interface tbb_cmd_if
  import tbb_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [1:0]        command;
  logic [1:0]        traffic_type;
  logic [SIZE_W-1:0] size_bytes;

  modport source (output valid, command, traffic_type, size_bytes, input ready);
  modport sink   (input valid, command, traffic_type, size_bytes, output ready);
endinterface

interface tbb_res_if;
  logic valid;
  logic ready;
  logic granted;
  logic renewed;

  modport source (output valid, granted, renewed, input ready);
  modport sink   (input valid, granted, renewed, output ready);
endinterface

// ----- rtl/tbb_cfg.sv -----
// tbb_cfg: apb register file and registered budget computation
// depends on tbb_pkg

module tbb_cfg
  import tbb_pkg::*;
#(
  parameter int unsigned NUM_TYPES = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ADDR_W-1:0]   paddr,
  input  logic [DATA_W-1:0]   pwdata,
  output logic [DATA_W-1:0]   prdata,
  output logic                pready,
  output logic [BUDGET_W-1:0] budget [NUM_TYPES],
  output cfg_ctrl_t           ctrl
);

  localparam int unsigned COMMON = NUM_TYPES - 1;
  localparam int unsigned SUM_W  = BUDGET_W + 3;

  logic [RATE_W-1:0]   total_rate;
  logic [SHARE_W-1:0]  share_pos;
  logic [SHARE_W-1:0]  share_dirty;
  logic [SHARE_W-1:0]  share_other;
  logic [TICK_W-1:0]   renew_ticks;
  logic [SETTLE_W-1:0] settle;
  logic                wr;
  reg_idx_e            idx;
  logic [BUDGET_W-1:0] interval;
  logic [BUDGET_W-1:0] bud [NUM_TYPES];
  logic [SUM_W-1:0]    reserved;

  assign wr       = psel & penable & pwrite;
  assign idx      = reg_idx_e'(paddr[4:2]);
  assign pready   = 1'b1;
  assign interval = BUDGET_W'(total_rate >> 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      total_rate  <= RATE_RESET;
      share_pos   <= '0;
      share_dirty <= '0;
      share_other <= '0;
      renew_ticks <= RENEW_RESET;
    end else if (wr) begin
      unique case (idx)
        REG_TOTAL_RATE:  total_rate  <= pwdata[RATE_W-1:0];
        REG_SHARE_POS:   share_pos   <= pwdata[SHARE_W-1:0];
        REG_SHARE_DIRTY: share_dirty <= pwdata[SHARE_W-1:0];
        REG_SHARE_OTHER: share_other <= pwdata[SHARE_W-1:0];
        REG_RENEW:       renew_ticks <= pwdata[TICK_W-1:0];
        default: ;
      endcase
    end
  end

  // budgets follow a write through the bud registers, the common one last; input is held off meanwhile
  always_ff @(posedge clk) begin
    if (rst) begin
      settle <= SETTLE_CYCLES;
    end else if (wr) begin
      settle <= SETTLE_CYCLES;
    end else if (settle != '0) begin
      settle <= settle - SETTLE_W'(1);
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      REG_TOTAL_RATE:  prdata = DATA_W'(total_rate);
      REG_SHARE_POS:   prdata = DATA_W'(share_pos);
      REG_SHARE_DIRTY: prdata = DATA_W'(share_dirty);
      REG_SHARE_OTHER: prdata = DATA_W'(share_other);
      REG_RENEW:       prdata = DATA_W'(renew_ticks);
      default:         prdata = '0;
    endcase
  end

  for (genvar i = 0; i < COMMON; i++) begin : g_res
    logic [SHARE_W-1:0]          share;
    logic [BUDGET_W+SHARE_W-1:0] prod;
    if (i == 0) begin : g_pos
      assign share = share_sat(share_pos);
    end else if (i == 1) begin : g_dirty
      assign share = share_sat(share_dirty);
    end else if (i == 2) begin : g_other
      assign share = share_sat(share_other);
    end else begin : g_none
      assign share = '0;
    end
    assign prod = BUDGET_W'(interval) * (BUDGET_W+SHARE_W)'(share);
    always_ff @(posedge clk) begin
      bud[i] <= prod[BUDGET_W+7:8];
    end
  end

  always_comb begin
    reserved = '0;
    for (int i = 0; i < COMMON; i++) begin
      reserved = reserved + SUM_W'(bud[i]);
    end
  end

  always_ff @(posedge clk) begin
    bud[COMMON] <= (reserved >= SUM_W'(interval)) ? '0
                   : BUDGET_W'(SUM_W'(interval) - reserved);
  end

  assign budget           = bud;
  assign ctrl.busy        = (settle != '0);
  assign ctrl.renew_ticks = renew_ticks;

endmodule

// ----- rtl/tbb_engine.sv -----
// tbb_engine: input register, usage counters, tick counter and result register
// depends on tbb_pkg and the channel interfaces in tbb_if

module tbb_engine
  import tbb_pkg::*;
#(
  parameter int unsigned NUM_TYPES   = 4,
  parameter int unsigned COUNT_WIDTH = 24
) (
  input  logic                clk,
  input  logic                rst,
  input  logic [BUDGET_W-1:0] budget [NUM_TYPES],
  input  cfg_ctrl_t           ctrl,
  tbb_cmd_if.sink             cmd,
  tbb_res_if.source           res
);

  localparam int unsigned COMMON = NUM_TYPES - 1;
  localparam int unsigned TIDX_W = (NUM_TYPES > 1) ? $clog2(NUM_TYPES) : 1;
  localparam int unsigned CMP_W  = (COUNT_WIDTH > BUDGET_W) ? COUNT_WIDTH : BUDGET_W;
  localparam logic [COUNT_WIDTH-1:0] CMAX = '1;
  localparam logic [TIDX_W-1:0]      CIDX = TIDX_W'(COMMON);
  localparam logic [TICK_W-1:0]      TMAX = '1;

  logic                   s1_valid;
  cmd_e                   s1_cmd;
  logic [1:0]             s1_type;
  logic [SIZE_W-1:0]      s1_size;
  logic                   adv;
  logic                   acc;

  logic [COUNT_WIDTH-1:0] used [NUM_TYPES];
  logic [COUNT_WIDTH-1:0] used_next [NUM_TYPES];
  logic [TICK_W-1:0]      ticks;
  logic [TICK_W-1:0]      ticks_next;
  logic [TICK_W-1:0]      ticks_inc;

  logic [TIDX_W-1:0]      t;
  logic [CMP_W-1:0]       used_t_x;
  logic [CMP_W-1:0]       bud_t_x;
  logic [COUNT_WIDTH:0]   sum_t;
  logic [COUNT_WIDTH-1:0] sat_t;
  logic [COUNT_WIDTH-1:0] excess;
  logic [COUNT_WIDTH:0]   sum_c;
  logic                   over;
  logic                   granted_next;
  logic                   renewed_next;

  assign adv       = s1_valid & (~res.valid | res.ready);
  assign cmd.ready = ~ctrl.busy & (~s1_valid | adv);
  assign acc       = cmd.valid & cmd.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= acc | (s1_valid & ~adv);
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_cmd  <= cmd_e'(cmd.command);
      s1_type <= cmd.traffic_type;
      s1_size <= cmd.size_bytes;
    end
  end

  always_comb begin
    t        = (int'(s1_type) >= int'(NUM_TYPES)) ? CIDX : TIDX_W'(s1_type);
    used_t_x = CMP_W'(used[t]);
    bud_t_x  = CMP_W'(budget[t]);
    sum_t    = (COUNT_WIDTH+1)'(used[t]) + (COUNT_WIDTH+1)'(s1_size);
    sat_t    = sum_t[COUNT_WIDTH] ? CMAX : sum_t[COUNT_WIDTH-1:0];
    over     = (t != CIDX) && (CMP_W'(sat_t) > bud_t_x);
    excess   = sat_t - COUNT_WIDTH'(budget[t]);
    sum_c    = (COUNT_WIDTH+1)'(used[COMMON]) + (COUNT_WIDTH+1)'(excess);
    ticks_inc = (ticks != TMAX) ? ticks + TICK_W'(1) : ticks;

    used_next    = used;
    ticks_next   = ticks;
    granted_next = 1'b0;
    renewed_next = 1'b0;

    unique case (s1_cmd)
      CMD_CHECK: begin
        granted_next = (used_t_x < bud_t_x)
                     || (CMP_W'(used[COMMON]) < CMP_W'(budget[COMMON]));
      end
      CMD_USE: begin
        if (over) begin
          used_next[t]      = COUNT_WIDTH'(budget[t]);
          used_next[COMMON] = sum_c[COUNT_WIDTH] ? CMAX : sum_c[COUNT_WIDTH-1:0];
        end else begin
          used_next[t] = sat_t;
        end
      end
      CMD_CUT: begin
        for (int i = 0; i < NUM_TYPES; i++) begin
          used_next[i] = (CMP_W'(budget[i]) > CMP_W'(CMAX)) ? CMAX
                         : COUNT_WIDTH'(budget[i]);
        end
        ticks_next = '0;
      end
      CMD_TICK: begin
        if (ticks_inc >= ctrl.renew_ticks) begin
          for (int i = 0; i < NUM_TYPES; i++) begin
            used_next[i] = '0;
          end
          ticks_next   = '0;
          renewed_next = 1'b1;
        end else begin
          ticks_next = ticks_inc;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_TYPES; i++) begin
        used[i] <= '0;
      end
      ticks <= '0;
    end else if (adv) begin
      used  <= used_next;
      ticks <= ticks_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else begin
      res.valid <= adv | (res.valid & ~res.ready);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res.granted <= granted_next;
      res.renewed <= renewed_next;
    end
  end

endmodule

// ----- rtl/typed_bandwidth_budget_core.sv -----
// typed_bandwidth_budget_core: per-type byte budget limiter with a shared pool
// depends on tbb_pkg, tbb_if, tbb_cfg and tbb_engine
//
// commands arrive on the cmd channel (check, use, cut, tick) with a traffic
// type and a size; every command yields exactly one result on the res
// channel carrying granted (checks) and renewed (ticks)
// a transferred command is held in the input register and its result then in
// the result register; one command per cycle is sustained while res is ready and
// no write is settling, limited by the single counter update stage between them
// the result register and the input register decouple the two sides: cmd
// keeps being taken while a result waits, until both registers are full;
// when res stalls, cmd ready drops and nothing is lost
// budgets are recomputed from the registers in a two-stage pipe (multiply,
// then the common remainder); after reset and after every apb write cmd
// ready stays low while they settle
// reset clears all usage counters and the tick counter, loads the register
// defaults and empties both pipeline registers
// apb writes take effect at the access edge; pready is always high

module typed_bandwidth_budget_core
  import tbb_pkg::*;
#(
  parameter int unsigned NUM_TYPES   = 4,
  parameter int unsigned COUNT_WIDTH = 24
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  tbb_cmd_if.sink           cmd,
  tbb_res_if.source         res
);

  logic [BUDGET_W-1:0] budget [NUM_TYPES];
  cfg_ctrl_t           ctrl;

  tbb_cfg #(
    .NUM_TYPES (NUM_TYPES)
  ) u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .budget  (budget),
    .ctrl    (ctrl)
  );

  tbb_engine #(
    .NUM_TYPES   (NUM_TYPES),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_engine (
    .clk    (clk),
    .rst    (rst),
    .budget (budget),
    .ctrl   (ctrl),
    .cmd    (cmd),
    .res    (res)
  );

endmodule

// ----- rtl/tbb_checker.sv -----
// tbb_checker: port-level assertions for typed_bandwidth_budget_core
// depends on tbb_pkg; bound to the top level at the end of this file

module tbb_checker
  import tbb_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic psel,
  input logic penable,
  input logic pwrite,
  input logic pready,
  input logic cmd_ready,
  input logic res_valid,
  input logic res_ready,
  input logic granted,
  input logic renewed
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid after reset");

  a_one_flag: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> !(granted && renewed))
    else $error("granted and renewed both set");

  a_write_holds_off: assert property (@(posedge clk) disable iff (rst)
    (psel && penable && pwrite) |=> !cmd_ready)
    else $error("command taken right after register write");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_ready) |=> (res_valid && $stable(granted) && $stable(renewed)))
    else $error("stalled result changed");

  a_pready: assert property (@(posedge clk) disable iff (rst) pready)
    else $error("pready low");

endmodule

bind typed_bandwidth_budget_core tbb_checker u_tbb_checker (
  .clk       (clk),
  .rst       (rst),
  .psel      (psel),
  .penable   (penable),
  .pwrite    (pwrite),
  .pready    (pready),
  .cmd_ready (cmd.ready),
  .res_valid (res.valid),
  .res_ready (res.ready),
  .granted   (res.granted),
  .renewed   (res.renewed)
);
